FILE: sv/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Types, codes and the note frequency table of the ringtone text parser.
// ----------------------------------------------------------------------------
`default_nettype none
package rtp_pkg;

  localparam logic [2:0] PH_TITLE = 3'd0;
  localparam logic [2:0] PH_HEAD  = 3'd1;
  localparam logic [2:0] PH_NOTES = 3'd2;
  localparam logic [2:0] PH_DRAIN = 3'd3;

  localparam logic [2:0] HS_PARAM = 3'd0;
  localparam logic [2:0] HS_EQUAL = 3'd1;
  localparam logic [2:0] HS_VALUE = 3'd2;
  localparam logic [2:0] HS_GAP   = 3'd3;

  localparam logic [2:0] NS_TOP    = 3'd0;
  localparam logic [2:0] NS_BODY   = 3'd1;
  localparam logic [2:0] NS_DIGITS = 3'd2;
  localparam logic [2:0] OS_SHARP  = 3'd1;
  localparam logic [2:0] OS_FLAT   = 3'd2;
  localparam logic [2:0] OS_DOT    = 3'd3;
  localparam logic [2:0] OS_OCT    = 3'd4;
  localparam logic [2:0] OS_DOT2   = 3'd5;
  localparam logic [2:0] OS_DELIM  = 3'd6;

  localparam logic [1:0] CFG_LEN = 2'd0;
  localparam logic [1:0] CFG_OCT = 2'd1;
  localparam logic [1:0] CFG_MS  = 2'd2;

  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_OPEN     = 2'd1;
  localparam logic [1:0] ST_SYNTAX   = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  localparam logic [5:0] PAUSE_SEMI = 6'd48;

  typedef struct packed {
    logic [0:0]  record_kind;
    logic [5:0]  semitone_index;
    logic [11:0] tone_hz;
    logic [7:0]  length_64ths;
    logic [15:0] length_ms;
    logic [10:0] notes_so_far;
    logic [1:0]  end_status;
    logic [0:0]  last_flag;
  } rec_t;

  // divider control: start with dividend/divisor, done with quotient
  typedef struct packed {
    logic        start;
    logic [11:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [11:0] quot;
  } div_rsp_t;

  function automatic logic [11:0] tone_of(input logic [5:0] s);
    logic [11:0] t;
    case (s)
      6'd0: t = 12'd261;   6'd1: t = 12'd277;   6'd2: t = 12'd293;
      6'd3: t = 12'd311;   6'd4: t = 12'd329;   6'd5: t = 12'd349;
      6'd6: t = 12'd370;   6'd7: t = 12'd392;   6'd8: t = 12'd415;
      6'd9: t = 12'd440;   6'd10: t = 12'd466;  6'd11: t = 12'd493;
      6'd12: t = 12'd523;  6'd13: t = 12'd554;  6'd14: t = 12'd587;
      6'd15: t = 12'd622;  6'd16: t = 12'd659;  6'd17: t = 12'd698;
      6'd18: t = 12'd740;  6'd19: t = 12'd784;  6'd20: t = 12'd830;
      6'd21: t = 12'd880;  6'd22: t = 12'd932;  6'd23: t = 12'd987;
      6'd24: t = 12'd1046; 6'd25: t = 12'd1108; 6'd26: t = 12'd1174;
      6'd27: t = 12'd1244; 6'd28: t = 12'd1318; 6'd29: t = 12'd1396;
      6'd30: t = 12'd1480; 6'd31: t = 12'd1568; 6'd32: t = 12'd1661;
      6'd33: t = 12'd1760; 6'd34: t = 12'd1864; 6'd35: t = 12'd1975;
      6'd36: t = 12'd2093; 6'd37: t = 12'd2217; 6'd38: t = 12'd2349;
      6'd39: t = 12'd2489; 6'd40: t = 12'd2637; 6'd41: t = 12'd2793;
      6'd42: t = 12'd2960; 6'd43: t = 12'd3136; 6'd44: t = 12'd3322;
      6'd45: t = 12'd3520; 6'd46: t = 12'd3729; 6'd47: t = 12'd3951;
      default: t = 12'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rtp_if.sv
// ----------------------------------------------------------------------------
// rtp_char_if / rtp_rec_if
// Valid/ready channels for text characters and result records.
// ----------------------------------------------------------------------------
`default_nettype none
interface rtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface rtp_rec_if;
  import rtp_pkg::*;
  logic valid;
  logic ready;
  rec_t rec;
  modport source (output valid, output rec, input ready);
  modport sink   (input valid, input rec, output ready);
endinterface
`default_nettype wire

FILE: sv/rtp_div.sv
// ----------------------------------------------------------------------------
// rtp_div
// Restoring divider, one quotient bit per cycle, 12-bit by 8-bit.
// ----------------------------------------------------------------------------
`default_nettype none
module rtp_div
  import rtp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [11:0] q_r, q_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  d_r, d_nxt;
  logic [8:0]  trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    trial    = {rem_r, q_r[11]} - {1'b0, d_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      q_nxt    = req.dividend;
      rem_nxt  = 8'd0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract if it fits
      if (!trial[8]) begin
        rem_nxt = trial[7:0];
        q_nxt   = {q_r[10:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[6:0], q_r[11]};
        q_nxt   = {q_r[10:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd11) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule
`default_nettype wire

FILE: sv/ringtone_text_to_note_parser.sv
// ----------------------------------------------------------------------------
// ringtone_text_to_note_parser
// Parses ringtone text one character per transaction into note and end records.
// ----------------------------------------------------------------------------
// a character is taken in S_IDLE; a duration or tempo division runs through
//   the shared 12-step divider in S_DIV; records are shown in S_OUT1/S_OUT2
// throughput: one character at a time, ready low during a division and while
//   records are shown
// reset: synchronous active low, registers to 16/24/59, parser to title phase
`default_nettype none
module ringtone_text_to_note_parser
  import rtp_pkg::*;
#(
  parameter int MAX_NOTES = 1024
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  rtp_char_if.sink        in_ch,
  rtp_rec_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int CW = $clog2(MAX_NOTES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_OUT1 = 3'd2;
  localparam logic [2:0] S_OUT2 = 3'd3;

  // what to do with the quotient
  localparam logic [1:0] DV_NLEN = 2'd0;
  localparam logic [1:0] DV_DLEN = 2'd1;
  localparam logic [1:0] DV_TEMPO = 2'd2;

  logic [2:0] st_r, st_nxt;
  logic [6:0] reg_len_r;
  logic [5:0] reg_oct_r;
  logic [7:0] reg_ms_r;

  logic [2:0] ph_r, ph_nxt, sub_r, sub_nxt;
  logic [7:0] acc_r, acc_nxt, hl_r, hl_nxt;
  logic [7:0] dlen_r, dlen_nxt, doct_r, doct_nxt, tempo_r, tempo_nxt;
  logic [7:0] psemi_r, psemi_nxt, plen_r, plen_nxt, poct_r, poct_nxt;
  logic       pv_r, pv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] c_r, c_nxt;
  logic [1:0] dv_r, dv_nxt;
  rec_t       r0_r, r0_nxt, r1_r, r1_nxt;
  logic       two_r, two_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  rtp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic isd(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] letter_semi(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      "C", "c": s = 8'd0;
      "D", "d": s = 8'd2;
      "E", "e": s = 8'd4;
      "F", "f": s = 8'd5;
      "G", "g": s = 8'd7;
      "A", "a": s = 8'd9;
      "H", "h", "B", "b": s = 8'd11;
      default: s = 8'd48;
    endcase
    return s;
  endfunction

  // first pass of a character in idle, and its second pass after a division finished
  always_comb begin
    logic [7:0] c, sum, dig;
    logic [5:0] semi;
    logic [15:0] prod;
    logic [11:0] q;
    logic nrec, done, fin, endr, skip;
    logic [1:0] est;
    logic [CW-1:0] cinc;
    st_nxt = st_r; ph_nxt = ph_r; sub_nxt = sub_r; acc_nxt = acc_r; hl_nxt = hl_r;
    dlen_nxt = dlen_r; doct_nxt = doct_r; tempo_nxt = tempo_r;
    psemi_nxt = psemi_r; plen_nxt = plen_r; poct_nxt = poct_r; pv_nxt = pv_r;
    cnt_nxt = cnt_r; c_nxt = c_r; dv_nxt = dv_r;
    r0_nxt = r0_r; r1_nxt = r1_r; two_nxt = two_r;
    dreq = '0;
    c = c_r; nrec = 1'b0; done = 1'b0; endr = 1'b0; est = ST_COMPLETE;
    fin = 1'b0; skip = 1'b0;
    dig = c_r - 8'h30;
    sum = 8'd0; semi = 6'd0; prod = 16'd0; q = drsp.quot;
    cinc = cnt_r + CW'(1);

    if (st_r == S_IDLE && in_ch.valid) begin
      c = in_ch.text_char;
      c_nxt = c;
      dig = c - 8'h30;
      case (ph_r)
        PH_TITLE: begin
          dlen_nxt = {1'b0, reg_len_r}; doct_nxt = {2'b0, reg_oct_r};
          tempo_nxt = reg_ms_r; cnt_nxt = '0; pv_nxt = 1'b0; sub_nxt = 3'd0;
          if (c == ":") begin ph_nxt = PH_HEAD; sub_nxt = HS_PARAM; end
          else if (c == 8'd0) begin endr = 1'b1; est = ST_SYNTAX; end
        end
        PH_HEAD: begin
          if (sub_r == HS_EQUAL) begin
            if (c != "=") begin endr = 1'b1; est = ST_SYNTAX; end
            else begin acc_nxt = 8'd0; sub_nxt = HS_VALUE; end
            skip = 1'b1;
          end else if (sub_r == HS_VALUE) begin
            if (isd(c)) begin
              acc_nxt = 8'((acc_r * 8'd10) + dig);
              skip = 1'b1;
            end else if (hl_r == "d" || hl_r == "b") begin
              if (acc_r == 8'd0) begin endr = 1'b1; est = ST_ZERO; end
              else begin
                dreq.start = 1'b1;
                dreq.dividend = (hl_r == "d") ? 12'd64 : 12'd3750;
                dreq.divisor = acc_r;
                dv_nxt = (hl_r == "d") ? DV_DLEN : DV_TEMPO;
                st_nxt = S_DIV;
              end
              skip = 1'b1;
            end else begin
              if (hl_r == "o") doct_nxt = 8'((acc_r + 8'd252) * 8'd12);
              sub_nxt = HS_GAP;
              fin = 1'b1;
            end
          end else fin = 1'b1;
          if (!skip && fin) begin
            // continue header from gap/param with this character
          end
        end
        PH_NOTES: begin
          if (pv_r) begin
            if (sub_r <= OS_SHARP && c == "#") begin
              psemi_nxt = psemi_r + 8'd1; sub_nxt = OS_FLAT; skip = 1'b1;
            end else if (sub_r <= OS_FLAT && c == "b") begin
              psemi_nxt = psemi_r - 8'd1; sub_nxt = OS_DOT; skip = 1'b1;
            end else if (sub_r <= OS_DOT && c == ".") begin
              plen_nxt = plen_r + (plen_r >> 1); sub_nxt = OS_OCT; skip = 1'b1;
            end else if (sub_r <= OS_OCT && isd(c)) begin
              poct_nxt = 8'((dig + 8'd252) * 8'd12); sub_nxt = OS_DOT2; skip = 1'b1;
            end else if (sub_r <= OS_DOT2 && c == ".") begin
              plen_nxt = plen_r + (plen_r >> 1); sub_nxt = OS_DELIM; skip = 1'b1;
            end else if (c == " ") begin
              sub_nxt = OS_DELIM; skip = 1'b1;
            end else begin
              nrec = 1'b1;
              sum = psemi_r + poct_r;
              semi = (sum > 8'd48) ? PAUSE_SEMI : sum[5:0];
              prod = plen_r * tempo_r;
              cnt_nxt = cinc;
              r0_nxt.record_kind = 1'b0;
              r0_nxt.semitone_index = semi;
              r0_nxt.tone_hz = tone_of(semi);
              r0_nxt.length_64ths = plen_r;
              r0_nxt.length_ms = prod;
              r0_nxt.notes_so_far = 11'(cinc);
              r0_nxt.end_status = ST_COMPLETE;
              pv_nxt = 1'b0; sub_nxt = NS_TOP;
              if (int'(cinc) >= MAX_NOTES) begin
                endr = 1'b1; est = ST_COMPLETE; skip = 1'b1;
              end else if (c == ",") skip = 1'b1;
            end
          end
          fin = 1'b1;
        end
        default: begin
          if (c == 8'd0) ph_nxt = PH_TITLE;
          skip = 1'b1;
        end
      endcase
      done = 1'b1;
    end else if (st_r == S_DIV && drsp.done) begin
      done = 1'b1; skip = 1'b1; st_nxt = S_IDLE;
      case (dv_r)
        DV_DLEN: begin dlen_nxt = q[7:0]; sub_nxt = HS_GAP; skip = 1'b0; fin = 1'b1; end
        DV_TEMPO: begin
          tempo_nxt = (q > 12'd255) ? 8'd255 : q[7:0];
          sub_nxt = HS_GAP; skip = 1'b0; fin = 1'b1;
        end
        default: begin
          // note letter with a duration number
          plen_nxt = q[7:0];
          if (c == 8'd0) begin endr = 1'b1; est = ST_OPEN; end
          else begin
            psemi_nxt = letter_semi(c); poct_nxt = doct_r;
            pv_nxt = 1'b1; sub_nxt = OS_SHARP;
          end
        end
      endcase
      nrec = two_r;
    end

    // header tail: gap and param handling on the current character
    if (done && !skip && fin && ph_r == PH_HEAD) begin
      skip = 1'b1;
      if (sub_nxt == HS_GAP && c == " ") begin
      end else if (sub_nxt == HS_GAP && c == ",") begin
        sub_nxt = HS_PARAM;
      end else if (c == " ") begin
        if (sub_nxt == HS_GAP) sub_nxt = HS_PARAM;
      end else if (c == 8'd0) begin
        endr = 1'b1; est = ST_SYNTAX;
      end else if (c == ":") begin
        ph_nxt = PH_NOTES; sub_nxt = NS_TOP; pv_nxt = 1'b0;
      end else begin
        hl_nxt = c; sub_nxt = HS_EQUAL;
      end
    end

    // note list body on the current character
    if (done && !skip && st_r == S_IDLE && ph_r == PH_NOTES) begin
      if (sub_nxt == NS_DIGITS) begin
        if (isd(c)) acc_nxt = 8'((acc_r * 8'd10) + dig);
        else if (acc_r == 8'd0) begin endr = 1'b1; est = ST_ZERO; end
        else begin
          dreq.start = 1'b1; dreq.dividend = 12'd64; dreq.divisor = acc_r;
          dv_nxt = DV_NLEN; st_nxt = S_DIV;
        end
      end else if (c == 8'd0) begin
        endr = 1'b1; est = (sub_nxt == NS_TOP) ? ST_COMPLETE : ST_OPEN;
      end else if (c == " ") sub_nxt = NS_BODY;
      else if (isd(c)) begin acc_nxt = dig; sub_nxt = NS_DIGITS; end
      else begin
        plen_nxt = dlen_r; psemi_nxt = letter_semi(c); poct_nxt = doct_r;
        pv_nxt = 1'b1; sub_nxt = OS_SHARP;
      end
    end

    if (done && st_nxt != S_DIV) begin
      if (endr) begin
        ph_nxt = (c == 8'd0) ? PH_TITLE : PH_DRAIN;
        sub_nxt = 3'd0; pv_nxt = 1'b0;
      end
      if (nrec && endr) begin
        r1_nxt = '0; r1_nxt.record_kind = 1'b1; r1_nxt.end_status = est;
        r1_nxt.notes_so_far = 11'(cnt_nxt); r1_nxt.last_flag = 1'b1;
        r0_nxt.last_flag = 1'b0; st_nxt = S_OUT1; two_nxt = 1'b1;
      end else if (endr) begin
        r0_nxt = '0; r0_nxt.record_kind = 1'b1; r0_nxt.end_status = est;
        r0_nxt.notes_so_far = 11'(cnt_nxt); r0_nxt.last_flag = 1'b1;
        st_nxt = S_OUT1; two_nxt = 1'b0;
      end else if (nrec) begin
        r0_nxt.last_flag = 1'b1; st_nxt = S_OUT1; two_nxt = 1'b0;
      end else st_nxt = S_IDLE;
    end else if (done && st_r == S_IDLE) begin
      // note record waits until the duration division finishes
      two_nxt = nrec;
      if (nrec) r0_nxt.last_flag = 1'b0;
    end

    if (st_r == S_OUT1 && out_ch.ready) st_nxt = two_r ? S_OUT2 : S_IDLE;
    if (st_r == S_OUT2 && out_ch.ready) st_nxt = S_IDLE;
    // a note record left over from a division step needs its last flag
    if (st_r == S_DIV && drsp.done && two_r && !endr) r0_nxt.last_flag = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_TITLE; sub_r <= 3'd0; acc_r <= 8'd0; hl_r <= 8'd0;
      reg_len_r <= 7'd16; reg_oct_r <= 6'd24; reg_ms_r <= 8'd59;
      dlen_r <= 8'd16; doct_r <= 8'd24; tempo_r <= 8'd59;
      psemi_r <= 8'd0; plen_r <= 8'd0; poct_r <= 8'd0; pv_r <= 1'b0;
      cnt_r <= '0; two_r <= 1'b0; dv_r <= DV_NLEN;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; sub_r <= sub_nxt; acc_r <= acc_nxt; hl_r <= hl_nxt;
      dlen_r <= dlen_nxt; doct_r <= doct_nxt; tempo_r <= tempo_nxt;
      psemi_r <= psemi_nxt; plen_r <= plen_nxt; poct_r <= poct_nxt; pv_r <= pv_nxt;
      cnt_r <= cnt_nxt; two_r <= two_nxt; dv_r <= dv_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEN: reg_len_r <= cfg_data[6:0];
          CFG_OCT: reg_oct_r <= cfg_data[5:0];
          CFG_MS:  reg_ms_r <= cfg_data;
          default: ;
        endcase
      end
    end
    c_r <= c_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt;
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT1) || (st_r == S_OUT2);
  assign out_ch.rec   = (st_r == S_OUT2) ? r1_r : r0_r;
endmodule
`default_nettype wire

FILE: sv/rtp_checker.sv
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks on the ringtone parser channels.
// ----------------------------------------------------------------------------
`default_nettype none
module rtp_checker
  import rtp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rec_t out_rec
);
  // no new character while a record is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while output valid");
  // once the last record of a character is taken the input opens again
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_rec.last_flag) |=> in_ready && !out_valid)
    else $error("not ready after last record");
  // note records carry no end status
  a_note_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rec.record_kind == 1'b0) |-> out_rec.end_status == ST_COMPLETE)
    else $error("status in note record");
  // a stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_rec))
    else $error("record changed while stalled");
endmodule

bind ringtone_text_to_note_parser rtp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rec(out_ch.rec));
`default_nettype wire

FILE: dv/tb_ringtone_text_to_note_parser.sv
// ----------------------------------------------------------------------------
// tb_ringtone_text_to_note_parser
// Feeds ringtone texts character by character and checks every record
// against a behavioral predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_ringtone_text_to_note_parser;
  import rtp_pkg::*;

  localparam int MAX_NOTES = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_LEN;
  logic [7:0] cfg_data = 8'd0;

  rtp_char_if in_ch ();
  rtp_rec_if out_ch ();

  ringtone_text_to_note_parser #(.MAX_NOTES(MAX_NOTES)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [7:0] reg_len_q, reg_oct_q, reg_ms_q;
  logic [2:0] phase_q, sub_q;
  logic [7:0] acc_q, hletter_q, dlen_q, doct_q, tempo_q;
  logic [7:0] psemi_q, plen_q, poct_q;
  logic pvalid_q;
  int unsigned ncount_q;

  rec_t expected_recs[$];
  rec_t step_recs[$];
  logic [7:0] pending_chars[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [11:0] hz_of(input logic [5:0] s);
    logic [11:0] t;
    case (s)
      0: t = 261; 1: t = 277; 2: t = 293; 3: t = 311; 4: t = 329; 5: t = 349;
      6: t = 370; 7: t = 392; 8: t = 415; 9: t = 440; 10: t = 466; 11: t = 493;
      12: t = 523; 13: t = 554; 14: t = 587; 15: t = 622; 16: t = 659;
      17: t = 698; 18: t = 740; 19: t = 784; 20: t = 830; 21: t = 880;
      22: t = 932; 23: t = 987; 24: t = 1046; 25: t = 1108; 26: t = 1174;
      27: t = 1244; 28: t = 1318; 29: t = 1396; 30: t = 1480; 31: t = 1568;
      32: t = 1661; 33: t = 1760; 34: t = 1864; 35: t = 1975; 36: t = 2093;
      37: t = 2217; 38: t = 2349; 39: t = 2489; 40: t = 2637; 41: t = 2793;
      42: t = 2960; 43: t = 3136; 44: t = 3322; 45: t = 3520; 46: t = 3729;
      47: t = 3951;
      default: t = 0;
    endcase
    return t;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_rec(input logic kind, input logic [5:0] semi, input logic [7:0] len,
                          input logic [15:0] ms, input logic [1:0] st);
    rec_t r;
    r.record_kind = kind;
    r.semitone_index = semi;
    r.tone_hz = kind ? 12'd0 : hz_of(semi);
    r.length_64ths = len;
    r.length_ms = ms;
    r.notes_so_far = ncount_q[10:0];
    r.end_status = st;
    r.last_flag = 1'b1;
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_flag = 1'b0;
    step_recs.push_back(r);
  endtask

  task automatic end_melody(input logic [1:0] st, input logic [7:0] c);
    push_rec(1'b1, 6'd0, 8'd0, 16'd0, st);
    phase_q = (c == 8'd0) ? PH_TITLE : PH_DRAIN;
    sub_q = 3'd0;
    pvalid_q = 1'b0;
  endtask

  task automatic flush_note(input logic [7:0] c);
    logic [7:0] s;
    logic [15:0] ms;
    s = psemi_q + poct_q;
    if (s > 8'd48) s = 8'd48;
    ncount_q++;
    ms = plen_q * tempo_q;
    push_rec(1'b0, s[5:0], plen_q, ms, ST_COMPLETE);
    pvalid_q = 1'b0;
    sub_q = NS_TOP;
    if (ncount_q >= MAX_NOTES) end_melody(ST_COMPLETE, c);
  endtask

  task automatic start_note(input logic [7:0] c);
    logic [7:0] s;
    if (c == 8'd0) begin
      end_melody(ST_OPEN, c);
    end else begin
      case (c)
        "C", "c": s = 0;
        "D", "d": s = 2;
        "E", "e": s = 4;
        "F", "f": s = 5;
        "G", "g": s = 7;
        "A", "a": s = 9;
        "H", "h", "B", "b": s = 11;
        default: s = 48;
      endcase
      psemi_q = s;
      poct_q = doct_q;
      pvalid_q = 1'b1;
      sub_q = OS_SHARP;
    end
  endtask

  task automatic notes_char(input logic [7:0] c);
    if (pvalid_q) begin
      if (sub_q <= OS_SHARP && c == "#") begin
        psemi_q++; sub_q = OS_FLAT; return;
      end
      if (sub_q <= OS_FLAT && c == "b") begin
        psemi_q--; sub_q = OS_DOT; return;
      end
      if (sub_q <= OS_DOT && c == ".") begin
        plen_q = plen_q + plen_q / 2; sub_q = OS_OCT; return;
      end
      if (sub_q <= OS_OCT && is_num(c)) begin
        poct_q = (c - 8'd48 + 8'd252) * 8'd12; sub_q = OS_DOT2; return;
      end
      if (sub_q <= OS_DOT2 && c == ".") begin
        plen_q = plen_q + plen_q / 2; sub_q = OS_DELIM; return;
      end
      if (c == " ") begin
        sub_q = OS_DELIM; return;
      end
      flush_note(c);
      if (phase_q != PH_NOTES || c == ",") return;
    end
    if (sub_q == NS_DIGITS) begin
      if (is_num(c)) begin
        acc_q = acc_q * 8'd10 + (c - 8'd48); return;
      end
      if (acc_q == 0) begin
        end_melody(ST_ZERO, c); return;
      end
      plen_q = 8'd64 / acc_q;
      start_note(c);
      return;
    end
    if (c == 8'd0) begin
      end_melody(sub_q == NS_TOP ? ST_COMPLETE : ST_OPEN, c); return;
    end
    if (c == " ") begin
      sub_q = NS_BODY; return;
    end
    if (is_num(c)) begin
      acc_q = c - 8'd48; sub_q = NS_DIGITS; return;
    end
    plen_q = dlen_q;
    start_note(c);
  endtask

  task automatic header_char(input logic [7:0] c);
    int unsigned v, q;
    if (sub_q == HS_EQUAL) begin
      if (c != "=") begin
        end_melody(ST_SYNTAX, c); return;
      end
      acc_q = 0; sub_q = HS_VALUE; return;
    end
    if (sub_q == HS_VALUE) begin
      v = acc_q;
      if (is_num(c)) begin
        acc_q = acc_q * 8'd10 + (c - 8'd48); return;
      end
      if (hletter_q == "d") begin
        if (v == 0) begin
          end_melody(ST_ZERO, c); return;
        end
        dlen_q = 64 / v;
      end else if (hletter_q == "o") begin
        doct_q = (v + 252) * 12;
      end else if (hletter_q == "b") begin
        if (v == 0) begin
          end_melody(ST_ZERO, c); return;
        end
        q = 3750 / v;
        tempo_q = (q > 255) ? 8'd255 : q[7:0];
      end
      sub_q = HS_GAP;
    end
    if (sub_q == HS_GAP) begin
      if (c == " ") return;
      sub_q = HS_PARAM;
      if (c == ",") return;
    end
    if (c == " ") return;
    if (c == 8'd0) begin
      end_melody(ST_SYNTAX, c); return;
    end
    if (c == ":") begin
      phase_q = PH_NOTES; sub_q = NS_TOP; pvalid_q = 1'b0; return;
    end
    hletter_q = c;
    sub_q = HS_EQUAL;
  endtask

  task automatic predict_char(input logic [7:0] c);
    step_recs.delete();
    case (phase_q)
      PH_TITLE: begin
        dlen_q = reg_len_q; doct_q = reg_oct_q; tempo_q = reg_ms_q;
        ncount_q = 0; pvalid_q = 1'b0; sub_q = 3'd0;
        if (c == ":") begin
          phase_q = PH_HEAD; sub_q = HS_PARAM;
        end else if (c == 8'd0) begin
          end_melody(ST_SYNTAX, c);
        end
      end
      PH_HEAD: header_char(c);
      PH_NOTES: notes_char(c);
      default: if (c == 8'd0) phase_q = PH_TITLE;
    endcase
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.text_char <= 8'd0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_char(in_ch.text_char);
      if (pending_chars.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.text_char <= pending_chars.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rec_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record %h", $time, out_ch.rec);
          errors++;
        end else begin
          want = expected_recs.pop_front();
          if (want !== out_ch.rec) begin
            $display("%0t: record mismatch expected %h actual %h", $time, want, out_ch.rec);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(8'd0);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() > 0 || in_ch.valid || expected_recs.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      CFG_LEN: reg_len_q = val & 8'h7f;
      CFG_OCT: reg_oct_q = val & 8'h3f;
      default: reg_ms_q = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic string rand_note();
    string s, letters;
    letters = "cdefgabhCDEFGABHxp";
    s = "";
    if ($urandom_range(2) == 0) s = {s, $sformatf("%0d", 1 << $urandom_range(6))};
    if ($urandom_range(19) == 0) s = {s, "0"};
    s = {s, string'(letters[$urandom_range(letters.len()-1)])};
    if ($urandom_range(3) == 0) s = {s, "#"};
    if ($urandom_range(5) == 0) s = {s, "b"};
    if ($urandom_range(3) == 0) s = {s, "."};
    if ($urandom_range(1) == 0) s = {s, $sformatf("%0d", $urandom_range(9))};
    if ($urandom_range(4) == 0) s = {s, "."};
    if ($urandom_range(3) == 0) s = {s, " "};
    return s;
  endfunction

  task automatic add_random_text();
    string s;
    int n;
    byte unsigned c;
    s = $urandom_range(1) ? "tune" : "";
    if ($urandom_range(9) == 0) begin
      // noise, arbitrary bytes
      n = $urandom_range(8, 1);
      repeat (n) begin
        c = $urandom_range(255, 1);
        s = {s, string'(c)};
      end
      add_text(s);
      return;
    end
    s = {s, ":"};
    if ($urandom_range(1)) s = {s, $sformatf("d=%0d,", 1 << $urandom_range(6))};
    if ($urandom_range(1)) s = {s, $sformatf("o=%0d, ", $urandom_range(9))};
    if ($urandom_range(1)) s = {s, $sformatf("b=%0d", $urandom_range(255))};
    if ($urandom_range(7) == 0) s = {s, "q 5"};
    s = {s, ":"};
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      s = {s, rand_note()};
      if (i < n - 1 || $urandom_range(3) == 0) s = {s, ","};
    end
    if ($urandom_range(5) == 0) s = {s, string'(byte'($urandom_range(255, 1)))};
    add_text(s);
  endtask

  initial begin
    int p;
    reg_len_q = 16; reg_oct_q = 24; reg_ms_q = 59;
    phase_q = PH_TITLE; sub_q = 0; acc_q = 0; hletter_q = 0;
    psemi_q = 0; plen_q = 0; poct_q = 0; pvalid_q = 0; ncount_q = 0;
    dlen_q = 16; doct_q = 24; tempo_q = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed texts
    add_text("abc:d=4,o=5,b=100:8c#6.,16db.,a,2p,h7..,x,32g#");
    add_text("t:d=0:c");
    add_text("t:b=0:c");
    add_text("t:o=9,b=1:c9,b#9, 0c");
    add_text("t:d=64,b=255,z=7 :4 ");
    add_text("t:q");
    add_text("title");
    add_text(":");
    add_text("t::");
    add_text("t::8");
    add_text({"t::c", string'(8'hff), "e"});
    wait_drained();

    write_reg(CFG_LEN, 8'hff);
    write_reg(CFG_OCT, 8'hff);
    write_reg(CFG_MS, 8'hff);
    add_text("t::c,d.,e#,p");
    wait_drained();
    write_reg(CFG_LEN, 8'd1);
    write_reg(CFG_OCT, 8'd0);
    write_reg(CFG_MS, 8'd1);
    add_text("t::c,b,g.");
    wait_drained();
    write_reg(CFG_LEN, 8'd16);
    write_reg(CFG_OCT, 8'd24);
    write_reg(CFG_MS, 8'd59);

    // random phases: none, sender idle, receiver stall, both
    for (p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 12 : 83) : 0;
      recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 12 : 83) : 0;
      write_reg(CFG_LEN, $urandom_range(64, 1));
      write_reg(CFG_OCT, $urandom_range(36));
      write_reg(CFG_MS, $urandom_range(255, 1));
      repeat (4) add_random_text();
      // let part of the queue go out, then pause the sender until all of it came back
      if (p == 1) begin
        repeat (150) @(posedge clk);
        hold_send = 1'b1;
        while (in_ch.valid || expected_recs.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      repeat (4) add_random_text();
      wait_drained();
    end

    if (errors == 0 && expected_recs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
